### hdl/websocket_frame_deframer_assert.svh
// Assertion macros for the WebSocket frame deframer.
// Used by the top level only; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wsd_pkg.sv
// Package for the WebSocket frame deframer: parser phases, error codes,
// result struct. No dependencies.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_STOPPED = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_RESERVED      = 3'd1,
        ERR_BAD_OPCODE    = 3'd2,
        ERR_CTRL_NOT_FIN  = 3'd3,
        ERR_ORPHAN_CONT   = 3'd4,
        ERR_CONT_EXPECTED = 3'd5,
        ERR_CTRL_TOO_LONG = 3'd6,
        ERR_STOPPED       = 3'd7
    } t_err;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    typedef struct packed {
        t_err       error_code;
        logic       masked_flag;
        logic [3:0] frame_opcode;
        logic       fin_flag;
        logic       end_of_frame;
        logic       has_byte;
        logic [7:0] payload_byte;
    } t_result;

endpackage

### hdl/wsd_parser.sv
// Frame parser: header, extended length, mask key and payload unmasking.
// State advances on each accepted byte. Depends on wsd_pkg.
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res,
    output logic             o_stopped
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic        r_cur_fin, n_cur_fin;
    logic [3:0]  r_cur_opcode, n_cur_opcode;
    logic        r_mask_present, n_mask_present;
    logic        r_mask_nonzero, n_mask_nonzero;
    logic [31:0] r_mask_key, n_mask_key;
    logic [2:0]  r_byte_counter, n_byte_counter;
    logic [63:0] r_remaining, n_remaining;
    logic [1:0]  r_mask_index, n_mask_index;
    logic [3:0]  r_pending, n_pending;

    logic        w_after_len;
    logic        w_after_hdr;
    logic        w_finish;
    logic        w_fin;
    logic [3:0]  w_op;
    logic [6:0]  w_len;
    logic [7:0]  w_key_byte;
    logic        w_last;

    always_comb begin
        n_phase        = r_phase;
        n_cur_fin      = r_cur_fin;
        n_cur_opcode   = r_cur_opcode;
        n_mask_present = r_mask_present;
        n_mask_nonzero = r_mask_nonzero;
        n_mask_key     = r_mask_key;
        n_byte_counter = r_byte_counter;
        n_remaining    = r_remaining;
        n_mask_index   = r_mask_index;
        n_pending      = r_pending;
        w_after_len    = 1'b0;
        w_after_hdr    = 1'b0;
        w_finish       = 1'b0;
        o_res_valid    = 1'b0;
        o_res          = '0;
        w_fin          = i_byte[7];
        w_op           = i_byte[3:0];
        w_len          = i_byte[6:0];
        w_last         = 1'b0;
        case (r_mask_index)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
        if (!r_mask_present) begin
            w_key_byte = 8'h00;
        end

        case (r_phase)
            wsd_pkg::PH_HDR0: begin
                o_res_valid = 1'b1;
                n_phase     = wsd_pkg::PH_STOPPED;
                if (i_byte[6:4] != 3'b000) begin
                    o_res.error_code = wsd_pkg::ERR_RESERVED;
                end else if (!(w_op <= wsd_pkg::OP_BIN ||
                               (w_op >= wsd_pkg::OP_CLOSE && w_op <= wsd_pkg::OP_PONG))) begin
                    o_res.error_code = wsd_pkg::ERR_BAD_OPCODE;
                end else if (w_op[3] && !w_fin) begin
                    o_res.error_code = wsd_pkg::ERR_CTRL_NOT_FIN;
                end else if (w_op == wsd_pkg::OP_CONT && r_pending == 4'h0) begin
                    o_res.error_code = wsd_pkg::ERR_ORPHAN_CONT;
                end else if (w_op != wsd_pkg::OP_CONT && !w_op[3] && r_pending != 4'h0) begin
                    o_res.error_code = wsd_pkg::ERR_CONT_EXPECTED;
                end else begin
                    o_res_valid    = 1'b0;
                    n_cur_fin      = w_fin;
                    n_cur_opcode   = (w_op == wsd_pkg::OP_CONT) ? r_pending : w_op;
                    n_mask_present = 1'b0;
                    n_mask_nonzero = 1'b0;
                    n_mask_key     = '0;
                    n_remaining    = '0;
                    n_mask_index   = '0;
                    n_byte_counter = '0;
                    n_phase        = wsd_pkg::PH_HDR1;
                end
            end
            wsd_pkg::PH_HDR1: begin
                if (r_cur_opcode[3] && w_len > wsd_pkg::LEN_CTRL_MAX) begin
                    o_res_valid      = 1'b1;
                    o_res.error_code = wsd_pkg::ERR_CTRL_TOO_LONG;
                    n_phase          = wsd_pkg::PH_STOPPED;
                end else begin
                    n_mask_present = i_byte[7];
                    if (w_len == wsd_pkg::LEN_EXT16 || w_len == wsd_pkg::LEN_EXT64) begin
                        n_remaining    = '0;
                        n_byte_counter = (w_len == wsd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
                        n_phase        = wsd_pkg::PH_EXTLEN;
                    end else begin
                        n_remaining = {57'd0, w_len};
                        w_after_len = 1'b1;
                    end
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                n_remaining = {r_remaining[55:0], i_byte};
                if (r_byte_counter == 3'd0) begin
                    w_after_len = 1'b1;
                end else begin
                    n_byte_counter = r_byte_counter - 3'd1;
                end
            end
            wsd_pkg::PH_MASK: begin
                n_mask_key = {r_mask_key[23:0], i_byte};
                if (i_byte != 8'h00) begin
                    n_mask_nonzero = 1'b1;
                end
                if (r_byte_counter == 3'd0) begin
                    w_after_hdr = 1'b1;
                end else begin
                    n_byte_counter = r_byte_counter - 3'd1;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                w_last             = (r_remaining == 64'd1);
                n_mask_index       = r_mask_index + 2'd1;
                n_remaining        = r_remaining - 64'd1;
                o_res_valid        = 1'b1;
                o_res.payload_byte = i_byte ^ w_key_byte;
                o_res.has_byte     = 1'b1;
                o_res.end_of_frame = w_last;
                o_res.fin_flag     = r_cur_fin;
                o_res.frame_opcode = r_cur_opcode;
                o_res.masked_flag  = r_mask_present & r_mask_nonzero;
                w_finish           = w_last;
            end
            default: begin
                o_res_valid      = 1'b1;
                o_res.error_code = wsd_pkg::ERR_STOPPED;
                n_phase          = wsd_pkg::PH_STOPPED;
            end
        endcase

        if (w_after_len) begin
            if (n_mask_present) begin
                n_phase        = wsd_pkg::PH_MASK;
                n_byte_counter = 3'd3;
            end else begin
                w_after_hdr = 1'b1;
            end
        end
        if (w_after_hdr) begin
            n_mask_index = '0;
            if (n_remaining == 64'd0) begin
                o_res_valid        = 1'b1;
                o_res.end_of_frame = 1'b1;
                o_res.fin_flag     = n_cur_fin;
                o_res.frame_opcode = n_cur_opcode;
                o_res.masked_flag  = n_mask_present & n_mask_nonzero;
                w_finish           = 1'b1;
            end else begin
                n_phase = wsd_pkg::PH_PAYLOAD;
            end
        end
        if (w_finish) begin
            if (!r_cur_opcode[3]) begin
                n_pending = r_cur_fin ? 4'h0 : r_cur_opcode;
            end
            n_phase = (r_cur_opcode == wsd_pkg::OP_CLOSE) ? wsd_pkg::PH_STOPPED
                                                         : wsd_pkg::PH_HDR0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= wsd_pkg::PH_HDR0;
            r_cur_fin      <= 1'b0;
            r_cur_opcode   <= '0;
            r_mask_present <= 1'b0;
            r_mask_nonzero <= 1'b0;
            r_mask_key     <= '0;
            r_byte_counter <= '0;
            r_remaining    <= '0;
            r_mask_index   <= '0;
            r_pending      <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_cur_fin      <= n_cur_fin;
            r_cur_opcode   <= n_cur_opcode;
            r_mask_present <= n_mask_present;
            r_mask_nonzero <= n_mask_nonzero;
            r_mask_key     <= n_mask_key;
            r_byte_counter <= n_byte_counter;
            r_remaining    <= n_remaining;
            r_mask_index   <= n_mask_index;
            r_pending      <= n_pending;
        end
    end

    assign o_stopped = (r_phase == wsd_pkg::PH_STOPPED);

endmodule

### hdl/wsd_out_reg.sv
// Output register for result transfers; frees as soon as the sink takes it.
// Depends on wsd_pkg.
module wsd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    input  logic             i_take,
    output logic             o_valid,
    output wsd_pkg::t_result o_res,
    output logic             o_can_load
);

    logic             r_valid, n_valid;
    wsd_pkg::t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid    = r_valid;
    assign o_res      = r_res;
    assign o_can_load = !r_valid || i_take;

endmodule

### hdl/websocket_frame_deframer.sv
// WebSocket frame deframer: one received byte per cycle in, at most one result out.
// A result is registered and presented in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle unless a result waits untaken in the output register,
// which is refilled in the cycle it drains. Reset (i_rst_n low, synchronous): parser
// returns to the first header byte, no open message, output register empty.
// Depends on wsd_pkg, wsd_parser, wsd_out_reg, websocket_frame_deframer_assert.svh.
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // end_of_frame
    output logic [9:0] m_axis_tuser    // [0] has_byte, [1] fin_flag, [5:2] frame_opcode,
                                       // [6] masked_flag, [9:7] error_code
);

    logic             w_accept;
    logic             w_res_valid;
    logic             w_load;
    logic             w_stopped;
    wsd_pkg::t_result w_res;
    wsd_pkg::t_result w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = w_accept && w_res_valid;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_stopped   (w_stopped)
    );

    wsd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_res      (w_res),
        .i_take     (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_res      (w_out),
        .o_can_load (s_axis_tready)
    );

    assign m_axis_tdata = w_out.payload_byte;
    assign m_axis_tlast = w_out.end_of_frame;
    assign m_axis_tuser = {w_out.error_code, w_out.masked_flag, w_out.frame_opcode,
                           w_out.fin_flag, w_out.has_byte};

    `WSD_ASSERT_IMP(a_err_clean, i_clk, i_rst_n,
        m_axis_tvalid && (w_out.error_code != wsd_pkg::ERR_NONE),
        !w_out.has_byte && !w_out.end_of_frame && !w_out.fin_flag && !w_out.masked_flag,
        "error result carries data or flags")

    `WSD_ASSERT_NXT(a_stop_after_err, i_clk, i_rst_n,
        w_load && (w_res.error_code != wsd_pkg::ERR_NONE),
        w_stopped,
        "parser not stopped after error result")

    `WSD_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n,
        !m_axis_tvalid,
        s_axis_tready,
        "input stalled with empty output register")

endmodule

### test/tb.sv
// Self-checking testbench for websocket_frame_deframer: drives framed byte streams,
// predicts every result with its own frame parser model and checks each output transfer.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam int FORM_MIN   = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;
    localparam int LONG_HOLD  = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES = 750;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [9:0] m_axis_tuser;

    // frame parser model state
    wsd_pkg::t_phase prs_phase = wsd_pkg::PH_HDR0;
    logic        frm_fin = 1'b0;
    logic [3:0]  frm_op = wsd_pkg::OP_CONT;
    logic        key_present = 1'b0;
    logic        key_nonzero = 1'b0;
    logic [31:0] key_word = '0;
    logic [2:0]  hdr_count = '0;
    logic [63:0] bytes_left = '0;
    logic [1:0]  key_pos = '0;
    logic [3:0]  open_msg_op = wsd_pkg::OP_CONT;

    wsd_pkg::t_result deframed_q[$];
    wsd_pkg::t_result seen_result;
    wsd_pkg::t_result want_result;
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      quiet_cycles = 0;
    int      hold_left = 0;
    logic    long_hold_req = 1'b0;
    logic    src_idle_en = 1'b1;
    logic    sink_idle_en = 1'b1;

    websocket_frame_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_result(input logic [7:0] data, input logic has,
                                        input logic eof, input wsd_pkg::t_err err);
        wsd_pkg::t_result r;
        r.payload_byte = data;
        r.has_byte     = has;
        r.end_of_frame = eof;
        r.fin_flag     = (err == wsd_pkg::ERR_NONE) ? frm_fin : 1'b0;
        r.frame_opcode = (err == wsd_pkg::ERR_NONE) ? frm_op : 4'h0;
        r.masked_flag  = (err == wsd_pkg::ERR_NONE) ? (key_present & key_nonzero) : 1'b0;
        r.error_code   = err;
        deframed_q.push_back(r);
    endfunction

    function automatic void stop_with(input wsd_pkg::t_err err);
        prs_phase = wsd_pkg::PH_STOPPED;
        push_result(8'h00, 1'b0, 1'b0, err);
    endfunction

    function automatic void frame_done();
        if (frm_op < wsd_pkg::OP_CLOSE)
            open_msg_op = frm_fin ? wsd_pkg::OP_CONT : frm_op;
        prs_phase = (frm_op == wsd_pkg::OP_CLOSE) ? wsd_pkg::PH_STOPPED : wsd_pkg::PH_HDR0;
    endfunction

    function automatic void header_done();
        key_pos = 2'd0;
        if (bytes_left == 64'd0) begin
            push_result(8'h00, 1'b0, 1'b1, wsd_pkg::ERR_NONE);
            frame_done();
        end else begin
            prs_phase = wsd_pkg::PH_PAYLOAD;
        end
    endfunction

    function automatic void length_done();
        if (key_present) begin
            prs_phase = wsd_pkg::PH_MASK;
            hdr_count = 3'd3;
        end else begin
            header_done();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [3:0] op;
        logic       ctrl;
        logic [6:0] len;
        logic [7:0] kb;
        op   = b[3:0];
        ctrl = (op >= wsd_pkg::OP_CLOSE);
        len  = b[6:0];
        case (prs_phase)
            wsd_pkg::PH_HDR0: begin
                if (b[6:4] != 3'b000)
                    stop_with(wsd_pkg::ERR_RESERVED);
                else if (!(op <= wsd_pkg::OP_BIN ||
                           (op >= wsd_pkg::OP_CLOSE && op <= wsd_pkg::OP_PONG)))
                    stop_with(wsd_pkg::ERR_BAD_OPCODE);
                else if (ctrl && !b[7])
                    stop_with(wsd_pkg::ERR_CTRL_NOT_FIN);
                else if (op == wsd_pkg::OP_CONT && open_msg_op == wsd_pkg::OP_CONT)
                    stop_with(wsd_pkg::ERR_ORPHAN_CONT);
                else if (op != wsd_pkg::OP_CONT && !ctrl && open_msg_op != wsd_pkg::OP_CONT)
                    stop_with(wsd_pkg::ERR_CONT_EXPECTED);
                else begin
                    frm_fin     = b[7];
                    frm_op      = (op == wsd_pkg::OP_CONT) ? open_msg_op : op;
                    key_present = 1'b0;
                    key_nonzero = 1'b0;
                    key_word    = '0;
                    bytes_left  = '0;
                    key_pos     = 2'd0;
                    hdr_count   = 3'd0;
                    prs_phase   = wsd_pkg::PH_HDR1;
                end
            end
            wsd_pkg::PH_HDR1: begin
                if (frm_op >= wsd_pkg::OP_CLOSE && len > wsd_pkg::LEN_CTRL_MAX) begin
                    stop_with(wsd_pkg::ERR_CTRL_TOO_LONG);
                end else begin
                    key_present = b[7];
                    if (len == wsd_pkg::LEN_EXT16 || len == wsd_pkg::LEN_EXT64) begin
                        bytes_left = '0;
                        hdr_count  = (len == wsd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
                        prs_phase  = wsd_pkg::PH_EXTLEN;
                    end else begin
                        bytes_left = 64'(len);
                        length_done();
                    end
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                bytes_left = {bytes_left[55:0], b};
                if (hdr_count == 3'd0)
                    length_done();
                else
                    hdr_count = hdr_count - 3'd1;
            end
            wsd_pkg::PH_MASK: begin
                key_word = {key_word[23:0], b};
                if (b != 8'h00)
                    key_nonzero = 1'b1;
                if (hdr_count == 3'd0)
                    header_done();
                else
                    hdr_count = hdr_count - 3'd1;
            end
            wsd_pkg::PH_PAYLOAD: begin
                kb = key_present ? key_word[8 * (3 - key_pos) +: 8] : 8'h00;
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                push_result(b ^ kb, 1'b1, bytes_left == 64'd0, wsd_pkg::ERR_NONE);
                if (bytes_left == 64'd0)
                    frame_done();
            end
            default: begin
                prs_phase = wsd_pkg::PH_STOPPED;
                deframed_q.push_back(wsd_pkg::t_result'{error_code: wsd_pkg::ERR_STOPPED,
                                                        default: '0});
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input wsd_pkg::t_result want,
                                          input wsd_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t %s: expected data=%h has=%b eof=%b fin=%b op=%h masked=%b err=%0d, ",
                   $realtime, what, want.payload_byte, want.has_byte, want.end_of_frame,
                   want.fin_flag, want.frame_opcode, want.masked_flag, want.error_code);
            $display("got data=%h has=%b eof=%b fin=%b op=%h masked=%b err=%0d",
                     got.payload_byte, got.has_byte, got.end_of_frame, got.fin_flag,
                     got.frame_opcode, got.masked_flag, got.error_code);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result.payload_byte = m_axis_tdata;
            seen_result.has_byte     = m_axis_tuser[0];
            seen_result.end_of_frame = m_axis_tlast;
            seen_result.fin_flag     = m_axis_tuser[1];
            seen_result.frame_opcode = m_axis_tuser[5:2];
            seen_result.masked_flag  = m_axis_tuser[6];
            seen_result.error_code   = wsd_pkg::t_err'(m_axis_tuser[9:7]);
            if (deframed_q.size() == 0) begin
                note_mismatch("unexpected result", '0, seen_result);
            end else begin
                want_result = deframed_q.pop_front();
                if (want_result.payload_byte !== seen_result.payload_byte ||
                    want_result.has_byte !== seen_result.has_byte ||
                    want_result.end_of_frame !== seen_result.end_of_frame ||
                    want_result.fin_flag !== seen_result.fin_flag ||
                    want_result.frame_opcode !== seen_result.frame_opcode ||
                    want_result.masked_flag !== seen_result.masked_flag ||
                    want_result.error_code !== seen_result.error_code)
                    note_mismatch("wrong result", want_result, seen_result);
            end
        end
    end

    // receiver: random ready bursts plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req) begin
            m_axis_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_req = 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= $urandom_range(0, 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL websocket_frame_deframer");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic drive_frame(input logic fin, input logic [3:0] op, input logic masked,
                               input logic [31:0] key, input int unsigned len, input int form);
        logic [6:0]  code;
        logic [63:0] len64;
        int          n_ext;
        len64 = 64'(len);
        if (form == FORM_EXT64 || len > 65535)
            code = wsd_pkg::LEN_EXT64;
        else if (form == FORM_EXT16 || len > 125)
            code = wsd_pkg::LEN_EXT16;
        else
            code = 7'(len);
        n_ext = (code == wsd_pkg::LEN_EXT64) ? 8 : (code == wsd_pkg::LEN_EXT16) ? 2 : 0;
        send_byte({fin, 3'b000, op});
        send_byte({masked, code});
        for (int i = n_ext - 1; i >= 0; i--)
            send_byte(len64[8 * i +: 8]);
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom));
    endtask

    // data frame with fin that is legal whether or not a message is open
    task automatic send_final_data(input int unsigned len);
        drive_frame(1'b1,
                    (open_msg_op != wsd_pkg::OP_CONT) ? wsd_pkg::OP_CONT : wsd_pkg::OP_BIN,
                    1'b1, $urandom, len, FORM_MIN);
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        logic [31:0] key;
        int unsigned len;
        int          form;
        int          pick;
        if ($urandom_range(0, 4) == 0) begin
            op  = $urandom_range(0, 1) ? OP_PING : wsd_pkg::OP_PONG;
            fin = 1'b1;
        end else begin
            if (open_msg_op != wsd_pkg::OP_CONT)
                op = wsd_pkg::OP_CONT;
            else
                op = $urandom_range(0, 1) ? OP_TEXT : wsd_pkg::OP_BIN;
            fin = 1'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            len = $urandom_range(0, 12);
        else if (pick < 9 || op >= wsd_pkg::OP_CLOSE)
            len = $urandom_range(13, 125);
        else
            len = $urandom_range(126, 300);
        form = FORM_MIN;
        if (len <= 125 && op < wsd_pkg::OP_CLOSE && $urandom_range(0, 9) == 0)
            form = $urandom_range(FORM_EXT16, FORM_EXT64);
        pick   = $urandom_range(0, 9);
        masked = (pick < 8);
        key    = (pick < 7) ? $urandom : 32'h0;
        drive_frame(fin, op, masked, key, len, form);
    endtask

    task automatic test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        drive_frame(1'b1, OP_TEXT, 1'b0, 32'h0, 0, FORM_MIN);
        drive_frame(1'b0, OP_TEXT, 1'b1, 32'h0, 1, FORM_MIN);
        drive_frame(1'b1, wsd_pkg::OP_PONG, 1'b0, 32'h0, 0, FORM_MIN);
        drive_frame(1'b1, wsd_pkg::OP_CONT, 1'b1, 32'hFFFF_FFFF, 2, FORM_EXT16);
    endtask

    task automatic test_random();
        while (bytes_sent < RANDOM_BYTES) begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
    endtask

    task automatic test_long_stall();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        long_hold_req = 1'b1;
        send_final_data(60);
    endtask

    task automatic test_drain_pause();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (3) send_random_frame();
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (3) send_random_frame();
    endtask

    // last part: one fatal event, then bytes answered in the stopped state
    task automatic test_termination();
        logic [7:0] b;
        int         pick;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        pick = $urandom_range(0, 6);
        if (pick == 0) begin
            drive_frame(1'b1, wsd_pkg::OP_CLOSE, 1'($urandom), $urandom,
                        $urandom_range(0, 5), FORM_MIN);
        end else begin
            case (wsd_pkg::t_err'(pick))
                wsd_pkg::ERR_RESERVED: begin
                    b = 8'($urandom);
                    b[6:4] = 3'($urandom_range(1, 7));
                    send_byte(b);
                end
                wsd_pkg::ERR_BAD_OPCODE:
                    send_byte({1'($urandom), 3'b000, $urandom_range(0, 1) ?
                               4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15))});
                wsd_pkg::ERR_CTRL_NOT_FIN:
                    send_byte({1'b0, 3'b000, 4'($urandom_range(8, 10))});
                wsd_pkg::ERR_ORPHAN_CONT: begin
                    if (open_msg_op != wsd_pkg::OP_CONT)
                        send_final_data(1);
                    send_byte({1'($urandom), 3'b000, wsd_pkg::OP_CONT});
                end
                wsd_pkg::ERR_CONT_EXPECTED: begin
                    if (open_msg_op == wsd_pkg::OP_CONT)
                        drive_frame(1'b0, OP_TEXT, 1'b0, 32'h0, 1, FORM_MIN);
                    send_byte({1'($urandom), 3'b000,
                               $urandom_range(0, 1) ? OP_TEXT : wsd_pkg::OP_BIN});
                end
                default: begin
                    send_byte({1'b1, 3'b000, 4'($urandom_range(8, 10))});
                    send_byte({1'($urandom),
                               $urandom_range(0, 1) ? wsd_pkg::LEN_EXT16 : wsd_pkg::LEN_EXT64});
                end
            endcase
        end
        repeat ($urandom_range(8, 20)) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_long_stall();
        test_drain_pause();
        test_termination();
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS websocket_frame_deframer");
        else
            $display("FAIL websocket_frame_deframer");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer.sv
test/tb.sv
